FILE: src/fls_pkg.sv
// Shared types and constants for the fade-out/fade-in level sequencer.
package fls_pkg;

    localparam int INDEX_W = 16;
    localparam int DUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 9;
    localparam int FRAC_W  = 8;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 9'd256;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               request;
        logic [INDEX_W-1:0] request_index;
        logic               rebase;
        logic [INDEX_W-1:0] current_index;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               swap_valid;
        logic [INDEX_W-1:0] swap_index;
        logic               needs_redraw;
        logic [INDEX_W-1:0] shown_index;
    } out_word_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OUT  = 2'd1,
        PH_IN   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_APPLY,
        S_TIME,
        S_EVAL,
        S_DIV,
        S_FIN
    } seq_state_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: src/fls_div.sv
// Radix-2 restoring divider that yields the fractional bits of numer / denom for numer < denom.
module fls_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fls_pkg::DUR_W-1:0] numer,
    input  logic [fls_pkg::DUR_W-1:0] denom,
    output fls_pkg::div_rsp_t         rsp
);

    localparam int CNT_W = $clog2(fls_pkg::FRAC_W);

    logic [fls_pkg::DUR_W-1:0]  rem_reg, rem_next;
    logic [fls_pkg::FRAC_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [fls_pkg::DUR_W:0] rem_shift;
    logic [fls_pkg::DUR_W:0] rem_diff;
    logic                    ge;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, denom};
    assign ge        = rem_shift >= {1'b0, denom};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_diff[fls_pkg::DUR_W-1:0] : rem_shift[fls_pkg::DUR_W-1:0];
            quot_next = {quot_reg[fls_pkg::FRAC_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(fls_pkg::FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: src/fade_out_in_level_sequencer_unit.sv
// Top level of the fade-out/fade-in level sequencer.
// Each input word is one display frame: time, optional fade request with its
// destination index, optional rebase flag and the caller's current index.
// Each accepted word yields exactly one output word with the brightness level,
// the one-shot swap report, the redraw flag and the index to show.
// Both channels use valid/ready; cfg_we writes the fade duration and is to be
// used only while the block is idle; the block itself does not enforce this.
// A frame runs through a short sequencer of four steps, then through an
// eight-step shared divider when a fade is in progress, then to the output
// register. A new word is accepted only after the previous one has left the
// sequencer for the output register.
// The output register holds a finished word while the receiver stalls, and the
// next frame can already be accepted and processed behind it; the sequencer
// waits at its last step until the output register is free.
// Reset puts the block in the idle phase with a zero duration, no pending
// destination and the settled flag set.
module fade_out_in_level_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fls_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output fls_pkg::out_word_t          out_data,
    input  logic                        cfg_we,
    input  logic [fls_pkg::DUR_W-1:0]   cfg_wdata
);

    fls_pkg::seq_state_t         state_reg, state_next;
    fls_pkg::in_word_t           item_reg, item_next;
    logic [fls_pkg::DUR_W-1:0]   dur_reg, dur_next;
    fls_pkg::phase_t             phase_reg, phase_next;
    logic [fls_pkg::TIME_W-1:0]  start_reg, start_next;
    logic                        pend_v_reg, pend_v_next;
    logic [fls_pkg::INDEX_W-1:0] pend_idx_reg, pend_idx_next;
    logic                        settled_reg, settled_next;
    logic [fls_pkg::TIME_W-1:0]  t_reg, t_next;
    logic [fls_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                        swap_v_reg, swap_v_next;
    logic [fls_pkg::INDEX_W-1:0] swap_idx_reg, swap_idx_next;
    fls_pkg::out_word_t          out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    logic [fls_pkg::TIME_W-1:0]  dur_ext;
    logic [fls_pkg::TIME_W-1:0]  elapsed;
    logic [fls_pkg::TIME_W-1:0]  since;
    logic                        t_lt_dur;
    logic                        div_go;
    logic                        out_free;
    logic                        accept;
    fls_pkg::div_rsp_t           div_rsp;

    assign dur_ext  = {{(fls_pkg::TIME_W - fls_pkg::DUR_W){1'b0}}, dur_reg};
    assign elapsed  = item_reg.now_ms - start_reg;
    assign since    = elapsed[fls_pkg::TIME_W-1] ? '0 : elapsed;
    assign t_lt_dur = t_reg < dur_ext;
    assign div_go   = (dur_reg != '0) && t_lt_dur
                      && ((phase_reg == fls_pkg::PH_OUT) || (phase_reg == fls_pkg::PH_IN));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == fls_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    fls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == fls_pkg::S_EVAL && div_go),
        .numer (t_reg[fls_pkg::DUR_W-1:0]),
        .denom (dur_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fls_pkg::S_IDLE:  if (accept) state_next = fls_pkg::S_PREP;
            fls_pkg::S_PREP:  state_next = fls_pkg::S_APPLY;
            fls_pkg::S_APPLY: state_next = fls_pkg::S_TIME;
            fls_pkg::S_TIME:  state_next = fls_pkg::S_EVAL;
            fls_pkg::S_EVAL:  state_next = div_go ? fls_pkg::S_DIV : fls_pkg::S_FIN;
            fls_pkg::S_DIV:   if (div_rsp.done) state_next = fls_pkg::S_FIN;
            fls_pkg::S_FIN:   if (out_free) state_next = fls_pkg::S_IDLE;
            default:          state_next = fls_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        dur_next       = cfg_we ? cfg_wdata : dur_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        pend_v_next    = pend_v_reg;
        pend_idx_next  = pend_idx_reg;
        settled_next   = settled_reg;
        t_next         = t_reg;
        level_next     = level_reg;
        swap_v_next    = swap_v_reg;
        swap_idx_next  = swap_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            fls_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next     = in_data;
                    level_next    = fls_pkg::FULL_LEVEL;
                    swap_v_next   = 1'b0;
                    swap_idx_next = '0;
                end
            end
            fls_pkg::S_PREP:
            begin
                t_next = (since > dur_ext) ? dur_ext : since;
            end
            fls_pkg::S_APPLY:
            begin
                if (item_reg.request)
                begin
                    pend_v_next   = 1'b1;
                    pend_idx_next = item_reg.request_index;
                    case (phase_reg)
                        fls_pkg::PH_OUT:
                        begin
                        end
                        fls_pkg::PH_IN:
                        begin
                            phase_next = fls_pkg::PH_OUT;
                            start_next = item_reg.now_ms + t_reg - dur_ext;
                        end
                        default:
                        begin
                            phase_next   = fls_pkg::PH_OUT;
                            start_next   = item_reg.now_ms;
                            settled_next = 1'b0;
                        end
                    endcase
                end
                else if (item_reg.rebase && phase_reg == fls_pkg::PH_IN)
                begin
                    start_next = item_reg.now_ms;
                end
            end
            fls_pkg::S_TIME:
            begin
                t_next = since;
            end
            fls_pkg::S_EVAL:
            begin
                if (dur_reg == '0)
                begin
                    if (phase_reg == fls_pkg::PH_OUT && pend_v_reg)
                    begin
                        swap_v_next   = 1'b1;
                        swap_idx_next = pend_idx_reg;
                    end
                    phase_next  = fls_pkg::PH_IDLE;
                    pend_v_next = 1'b0;
                end
                else if (phase_reg == fls_pkg::PH_OUT && !t_lt_dur)
                begin
                    if (pend_v_reg)
                    begin
                        swap_v_next   = 1'b1;
                        swap_idx_next = pend_idx_reg;
                    end
                    phase_next  = fls_pkg::PH_IN;
                    start_next  = item_reg.now_ms;
                    pend_v_next = 1'b0;
                    level_next  = '0;
                end
                else if (phase_reg == fls_pkg::PH_IN && !t_lt_dur)
                begin
                    phase_next = fls_pkg::PH_IDLE;
                end
            end
            fls_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (phase_reg == fls_pkg::PH_OUT)
                    begin
                        level_next = fls_pkg::FULL_LEVEL - {1'b0, div_rsp.quot};
                    end
                    else
                    begin
                        level_next = {1'b0, div_rsp.quot};
                    end
                end
            end
            fls_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.level      = level_reg;
                    out_next.swap_valid = swap_v_reg;
                    out_next.swap_index = swap_idx_reg;
                    if (phase_reg == fls_pkg::PH_OUT || phase_reg == fls_pkg::PH_IN)
                    begin
                        out_next.needs_redraw = 1'b1;
                    end
                    else
                    begin
                        out_next.needs_redraw = !settled_reg;
                        settled_next          = 1'b1;
                    end
                    if (phase_reg == fls_pkg::PH_OUT && pend_v_reg)
                    begin
                        out_next.shown_index = pend_idx_reg;
                    end
                    else
                    begin
                        out_next.shown_index = item_reg.current_index;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fls_pkg::S_IDLE;
            dur_reg       <= '0;
            phase_reg     <= fls_pkg::PH_IDLE;
            start_reg     <= '0;
            pend_v_reg    <= 1'b0;
            pend_idx_reg  <= '0;
            settled_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dur_reg       <= dur_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            pend_v_reg    <= pend_v_next;
            pend_idx_reg  <= pend_idx_next;
            settled_reg   <= settled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        t_reg        <= t_next;
        level_reg    <= level_next;
        swap_v_reg   <= swap_v_next;
        swap_idx_reg <= swap_idx_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: test/fls_checker.sv
// Checker for the fade level sequencer: watches both channels, predicts each output word and compares.
module fls_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  fls_pkg::in_word_t         in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  fls_pkg::out_word_t        out_data,
    input  logic                      cfg_we,
    input  logic [fls_pkg::DUR_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        outstanding,
    output int                        words_checked,
    output int                        swaps_seen
);

    fls_pkg::phase_t                     fade_phase;
    logic [fls_pkg::TIME_W-1:0]          fade_start;
    logic                                dest_valid;
    logic [fls_pkg::INDEX_W-1:0]         dest_index;
    logic                                settled_flag;
    logic [fls_pkg::DUR_W-1:0]           fade_len;
    fls_pkg::out_word_t                  expected_frames[$];
    int                                  n_fail;
    int                                  n_checked;
    int                                  n_swaps;

    function automatic logic [fls_pkg::TIME_W-1:0] elapsed(logic [fls_pkg::TIME_W-1:0] now);
        logic [fls_pkg::TIME_W-1:0] d;
        d = now - fade_start;
        return d[fls_pkg::TIME_W-1] ? '0 : d;
    endfunction

    function automatic logic [fls_pkg::LEVEL_W-1:0] scaled(logic [fls_pkg::TIME_W-1:0] t);
        logic [63:0] q;
        q = (64'(fls_pkg::FULL_LEVEL) * 64'(t)) / 64'(fade_len);
        return q[fls_pkg::LEVEL_W-1:0];
    endfunction

    function automatic fls_pkg::out_word_t frame_result(fls_pkg::in_word_t w);
        logic [fls_pkg::TIME_W-1:0] t;
        logic [fls_pkg::TIME_W-1:0] span;
        fls_pkg::out_word_t r;
        span = fls_pkg::TIME_W'(fade_len);
        r = '0;
        r.level = fls_pkg::FULL_LEVEL;
        if (w.request)
        begin
            if (fade_phase == fls_pkg::PH_OUT)
            begin
                dest_index = w.request_index;
                dest_valid = 1'b1;
            end
            else if (fade_phase == fls_pkg::PH_IN)
            begin
                t = elapsed(w.now_ms);
                if (t > span) t = span;
                fade_phase = fls_pkg::PH_OUT;
                fade_start = w.now_ms - (span - t);
                dest_index = w.request_index;
                dest_valid = 1'b1;
            end
            else
            begin
                fade_phase = fls_pkg::PH_OUT;
                fade_start = w.now_ms;
                dest_index = w.request_index;
                dest_valid = 1'b1;
                settled_flag = 1'b0;
            end
        end
        if (w.rebase && fade_phase == fls_pkg::PH_IN) fade_start = w.now_ms;
        if (fade_len == '0)
        begin
            if (fade_phase == fls_pkg::PH_OUT && dest_valid)
            begin
                r.swap_valid = 1'b1;
                r.swap_index = dest_index;
            end
            fade_phase = fls_pkg::PH_IDLE;
            dest_valid = 1'b0;
        end
        else if (fade_phase == fls_pkg::PH_OUT)
        begin
            t = elapsed(w.now_ms);
            if (t < span)
            begin
                r.level = fls_pkg::FULL_LEVEL - scaled(t);
            end
            else
            begin
                if (dest_valid)
                begin
                    r.swap_valid = 1'b1;
                    r.swap_index = dest_index;
                end
                fade_phase = fls_pkg::PH_IN;
                fade_start = w.now_ms;
                dest_valid = 1'b0;
                r.level = '0;
            end
        end
        else if (fade_phase == fls_pkg::PH_IN)
        begin
            t = elapsed(w.now_ms);
            if (t < span) r.level = scaled(t);
            else fade_phase = fls_pkg::PH_IDLE;
        end
        if (fade_phase == fls_pkg::PH_OUT || fade_phase == fls_pkg::PH_IN)
        begin
            r.needs_redraw = 1'b1;
        end
        else if (!settled_flag)
        begin
            settled_flag = 1'b1;
            r.needs_redraw = 1'b1;
        end
        r.shown_index = (fade_phase == fls_pkg::PH_OUT && dest_valid)
                        ? dest_index : w.current_index;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fls_pkg::out_word_t want;
        logic bad;
        if (!rst_n)
        begin
            fade_phase = fls_pkg::PH_IDLE;
            fade_start = '0;
            dest_valid = 1'b0;
            dest_index = '0;
            settled_flag = 1'b1;
            fade_len = '0;
            expected_frames.delete();
            n_fail = 0;
            n_checked = 0;
            n_swaps = 0;
        end
        else
        begin
            if (cfg_we) fade_len = cfg_wdata;
            if (in_valid && in_ready)
            begin
                want = frame_result(in_data);
                if (want.swap_valid) n_swaps++;
                expected_frames.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("Output word with nothing expected: level %0d swap %0b/%h",
                                 out_data.level, out_data.swap_valid, out_data.swap_index);
                    n_fail++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    bad = (out_data.level !== want.level)
                        || (out_data.swap_valid !== want.swap_valid)
                        || (out_data.swap_index !== want.swap_index)
                        || (out_data.needs_redraw !== want.needs_redraw)
                        || (out_data.shown_index !== want.shown_index);
                    if (bad)
                    begin
                        if (n_fail < 10)
                        begin
                            $display("Word %0d mismatch: expected level %0d swap %0b/%h %s",
                                     n_checked, want.level, want.swap_valid,
                                     want.swap_index, "redraw and shown below");
                            $display("    expected redraw %0b shown %h",
                                     want.needs_redraw, want.shown_index);
                            $display("    actual level %0d swap %0b/%h redraw %0b shown %h",
                                     out_data.level, out_data.swap_valid, out_data.swap_index,
                                     out_data.needs_redraw, out_data.shown_index);
                        end
                        n_fail++;
                    end
                    n_checked++;
                end
            end
        end
        fail_count    <= n_fail;
        outstanding   <= expected_frames.size();
        words_checked <= n_checked;
        swaps_seen    <= n_swaps;
    end

endmodule

FILE: test/tb_fade_out_in_level_sequencer_unit.sv
// Testbench top for the fade level sequencer: reset, stimulus, output stalls and the verdict.
module tb_fade_out_in_level_sequencer_unit;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    fls_pkg::in_word_t           in_data = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    fls_pkg::out_word_t          out_data;
    logic                        cfg_we = 1'b0;
    logic [fls_pkg::DUR_W-1:0]   cfg_wdata = '0;

    int                          fail_count;
    int                          outstanding;
    int                          words_checked;
    int                          swaps_seen;
    int                          send_idle = 0;
    int                          recv_idle = 0;
    int                          hold_asked = 0;
    int                          settings_used = 0;
    logic [fls_pkg::DUR_W-1:0]   dur_now = '0;
    logic [fls_pkg::TIME_W-1:0]  clock_ms = '0;
    logic [fls_pkg::DUR_W-1:0]   durations [7];

    fade_out_in_level_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fls_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .swaps_seen    (swaps_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d words outstanding", cycles, outstanding);
        $display("FAIL");
        $finish;
    end

    // A long hold-off lets the block fill up and stall its input.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    function automatic fls_pkg::in_word_t frame(logic [fls_pkg::TIME_W-1:0] now, logic req,
                                                logic [fls_pkg::INDEX_W-1:0] req_idx,
                                                logic reb,
                                                logic [fls_pkg::INDEX_W-1:0] cur_idx);
        fls_pkg::in_word_t w;
        w.now_ms = now;
        w.request = req;
        w.request_index = req_idx;
        w.rebase = reb;
        w.current_index = cur_idx;
        return w;
    endfunction

    function automatic logic [fls_pkg::INDEX_W-1:0] pick_index();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return '0;
        if (kind == 1) return '1;
        return fls_pkg::INDEX_W'($urandom());
    endfunction

    task automatic send_frame(input fls_pkg::in_word_t w);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic set_duration(input logic [fls_pkg::DUR_W-1:0] d);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        dur_now = d;
        settings_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly forward time steps sized to the fade, with overshoots, steps back and wild jumps.
    task automatic next_random_frame(output fls_pkg::in_word_t w);
        int kind;
        int span;
        kind = $urandom_range(0, 99);
        span = int'(dur_now);
        if (kind < 80) clock_ms = clock_ms + $urandom_range(0, span / 3 + 2);
        else if (kind < 88) clock_ms = clock_ms + $urandom_range(0, 3 * span + 10);
        else if (kind < 94) clock_ms = clock_ms - $urandom_range(1, span + 5);
        else clock_ms = $urandom();
        w = frame(clock_ms, $urandom_range(0, 11) == 0, pick_index(),
                  $urandom_range(0, 9) == 0, pick_index());
    endtask

    initial
    begin
        fls_pkg::in_word_t w;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Zero duration after reset: the swap is reported at once.
        send_frame(frame(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 16'h0000));
        send_frame(frame(32'h0000_0000, 1'b0, 16'h0000, 1'b0, 16'hFFFF));

        set_duration(16'd8);
        send_frame(frame(32'd1000, 1'b0, 16'h0000, 1'b1, 16'h0011));
        send_frame(frame(32'd1000, 1'b1, 16'h1234, 1'b0, 16'h0011));
        send_frame(frame(32'd1002, 1'b0, 16'hFFFF, 1'b0, 16'h0011));
        send_frame(frame(32'd1004, 1'b1, 16'h00FF, 1'b0, 16'h0011));
        send_frame(frame(32'd990,  1'b0, 16'h0000, 1'b0, 16'h0011));
        send_frame(frame(32'd1008, 1'b0, 16'h0000, 1'b0, 16'h0022));
        send_frame(frame(32'd1010, 1'b0, 16'h0000, 1'b0, 16'h0022));
        send_frame(frame(32'd1012, 1'b0, 16'h0000, 1'b1, 16'h0022));
        send_frame(frame(32'd1015, 1'b0, 16'h0000, 1'b0, 16'h0022));
        send_frame(frame(32'd1015, 1'b1, 16'h0000, 1'b0, 16'h0022));
        send_frame(frame(32'd1018, 1'b0, 16'h0000, 1'b0, 16'h0033));
        send_frame(frame(32'd1026, 1'b0, 16'h0000, 1'b0, 16'h0033));
        send_frame(frame(32'd1030, 1'b0, 16'h0000, 1'b0, 16'h0033));
        // A fade across the wrap of the millisecond counter.
        send_frame(frame(32'hFFFF_FFFC, 1'b1, 16'hA5A5, 1'b0, 16'h0044));
        send_frame(frame(32'h0000_0002, 1'b0, 16'h0000, 1'b0, 16'h0044));
        send_frame(frame(32'h0000_0004, 1'b0, 16'h0000, 1'b0, 16'h0044));
        send_frame(frame(32'h0000_0100, 1'b1, 16'h5A5A, 1'b0, 16'h0055));
        send_frame(frame(32'h0000_0200, 1'b0, 16'h0000, 1'b0, 16'h0055));
        send_frame(frame(32'h8000_0300, 1'b0, 16'h0000, 1'b0, 16'h0055));
        send_frame(frame(32'h0000_0208, 1'b0, 16'h0000, 1'b0, 16'h0055));

        durations[0] = 16'd1;
        durations[1] = 16'hFFFF;
        durations[2] = 16'd0;
        durations[3] = fls_pkg::DUR_W'($urandom_range(2, 4000));
        durations[4] = 16'hFFFF;
        durations[5] = fls_pkg::DUR_W'($urandom_range(1, 65535));
        durations[6] = 16'd16;
        clock_ms = $urandom();

        for (int p = 0; p < 7; p++)
        begin
            set_duration(durations[p]);
            if (p < 3)
            begin
                send_idle = 35;
                recv_idle = 67;
            end
            else if (p < 5)
            begin
                send_idle = 67;
                recv_idle = 35;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < 100; i++)
            begin
                if (i == 50 && (p == 1 || p == 5)) hold_asked <= hold_asked + 1;
                if (i == 50 && p == 3) wait_drained();
                next_random_frame(w);
                send_frame(w);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d output words over %0d duration settings, zero and maximum included;",
                 words_checked, settings_used);
        $display("fade sequences saw %0d swaps, time jumps, counter wrap and long output stalls.",
                 swaps_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: fade_out_in_level_sequencer_unit.f
src/fls_pkg.sv
src/fls_div.sv
src/fade_out_in_level_sequencer_unit.sv
test/fls_checker.sv
test/tb_fade_out_in_level_sequencer_unit.sv
